/* rtl/arpc_pkg.sv */
// shared types and codes for the address cache
package arpc_pkg;

  // action codes
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int COUNT_W = 5;

  // one table entry
  typedef struct packed {
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } entry_t;

  // answer handed from the sequencer to the output register
  typedef struct packed {
    logic [1:0]       status;
    logic [MAC_W-1:0] found_mac;
  } result_t;

endpackage

/* rtl/arpc_if.sv */
// valid/ready channel interfaces for request and answer words

interface arpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [arpc_pkg::IP_W-1:0]     ip_address;
  logic [arpc_pkg::MAC_W-1:0]    mac_address;

  modport source (output valid, action, ip_address, mac_address, input ready);
  modport sink (input valid, action, ip_address, mac_address, output ready);
endinterface

interface arpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [arpc_pkg::MAC_W-1:0]    found_mac;
  logic [arpc_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found_mac, entry_count, input ready);
  modport sink (input valid, status, found_mac, entry_count, output ready);
endinterface

/* rtl/arpc_table.sv */
// entry memory: one write port, one registered read port
module arpc_table #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic                     clk,
  input  logic [IDX_W-1:0]         rd_addr,
  output arpc_pkg::entry_t         rd_data,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_addr,
  input  arpc_pkg::entry_t         wr_data
);

  arpc_pkg::entry_t mem_r [ENTRIES];
  arpc_pkg::entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/arpc_seq.sv */
// sequencer: walks the table with one comparator and one index incrementer
module arpc_seq #(
  parameter int TABLE_ENTRIES = 16,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [arpc_pkg::IP_W-1:0]     in_ip,
  input  logic [arpc_pkg::MAC_W-1:0]    in_mac,
  output logic [IDX_W-1:0]              rd_addr,
  input  arpc_pkg::entry_t              rd_data,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output arpc_pkg::entry_t              wr_data,
  output logic                          res_valid,
  input  logic                          res_take,
  output arpc_pkg::result_t             res,
  output logic [CNT_W-1:0]              count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_RESOLVE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  state_t                        state_r;
  logic [1:0]                    action_r;
  logic [arpc_pkg::IP_W-1:0]     key_r;
  logic [arpc_pkg::MAC_W-1:0]    mac_r;
  logic [arpc_pkg::MAC_W-1:0]    found_r;
  logic                          hit_r;
  logic [CNT_W-1:0]              idx_r;
  logic [CNT_W-1:0]              count_r;
  arpc_pkg::result_t             res_r;

  logic [CNT_W:0]                idx_inc;
  logic [CNT_W:0]                count_ext;
  logic [CNT_W:0]                count_dec;
  logic                          full;
  logic                          key_match;

  // shared incrementer and comparator
  assign idx_inc   = {1'b0, idx_r} + {{CNT_W{1'b0}}, 1'b1};
  assign count_ext = {1'b0, count_r};
  assign count_dec = count_ext - {{CNT_W{1'b0}}, 1'b1};
  assign full      = (count_r == CNT_W'(TABLE_ENTRIES));
  assign key_match = (rd_data.ip == key_r);

  // memory ports
  always_comb begin
    rd_addr = idx_r[IDX_W-1:0];
    if (state_r == S_SHIFT_RD) begin
      rd_addr = idx_inc[IDX_W-1:0];
    end
    wr_en   = 1'b0;
    wr_addr = idx_r[IDX_W-1:0];
    wr_data = '{ip: key_r, mac: mac_r};
    if (state_r == S_SHIFT_WR) begin
      wr_en   = 1'b1;
      wr_data = rd_data;
    end else if (state_r == S_RESOLVE && action_r == arpc_pkg::ACT_SET) begin
      if (hit_r) begin
        wr_en = 1'b1;
      end else if (!full) begin
        wr_en   = 1'b1;
        wr_addr = count_r[IDX_W-1:0];
      end
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;
  assign count     = count_r;

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      hit_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            action_r <= in_action;
            key_r    <= in_ip;
            mac_r    <= in_mac;
            hit_r    <= 1'b0;
            idx_r    <= '0;
            state_r  <= (count_r == '0) ? S_RESOLVE : S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state_r <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (key_match) begin
            hit_r   <= 1'b1;
            found_r <= rd_data.mac;
            state_r <= S_RESOLVE;
          end else if (idx_inc == count_ext) begin
            state_r <= S_RESOLVE;
          end else begin
            idx_r   <= idx_inc[CNT_W-1:0];
            state_r <= S_SCAN_RD;
          end
        end
        S_RESOLVE: begin
          res_r.found_mac <= '0;
          res_r.status    <= arpc_pkg::ST_MISS;
          state_r         <= S_DONE;
          case (action_r)
            arpc_pkg::ACT_LOOKUP: begin
              if (hit_r) begin
                res_r.status    <= arpc_pkg::ST_OK;
                res_r.found_mac <= found_r;
              end
            end
            arpc_pkg::ACT_SET: begin
              if (hit_r) begin
                res_r.status <= arpc_pkg::ST_OK;
              end else if (full) begin
                res_r.status <= arpc_pkg::ST_FULL;
              end else begin
                res_r.status <= arpc_pkg::ST_OK;
                count_r      <= idx_inc[CNT_W-1:0] + count_r - idx_r;
              end
            end
            arpc_pkg::ACT_REMOVE: begin
              if (hit_r) begin
                res_r.status <= arpc_pkg::ST_OK;
                if (idx_inc == count_ext) begin
                  count_r <= count_dec[CNT_W-1:0];
                end else begin
                  state_r <= S_SHIFT_RD;
                end
              end
            end
            default: begin
              res_r.status <= arpc_pkg::ST_MISS;
            end
          endcase
        end
        S_SHIFT_RD: begin
          state_r <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          idx_r <= idx_inc[CNT_W-1:0];
          if (idx_inc == count_dec) begin
            count_r <= count_dec[CNT_W-1:0];
            state_r <= S_DONE;
          end else begin
            state_r <= S_SHIFT_RD;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/arp_address_cache.sv */
// top level of the IPv4-to-MAC address cache
//
// Request words arrive on in_ch: an action (lookup, set, remove), an IPv4
// address and, for set, a MAC. Each request gives exactly one answer word on
// out_ch: a status (found/success, not found, table full), the MAC found by a
// lookup (zero otherwise) and the entry count after the operation.
// The table keeps its valid entries packed at the lowest places. One shared
// comparator walks them, a read state and then a compare state for each
// entry visited, because the entry memory has a single registered read
// port. A remove then moves every later entry down one place, with a read
// state and then a write state for each entry moved. A search stops at the
// first match or after the last valid entry. One request is in flight at
// a time; in_ch.ready is high only while the sequencer is idle, so a new
// request is taken only once the sequencer has passed on its last answer.
// The answer sits in an output register, so the next request is taken while
// a stalled receiver holds out_ch.ready low; the sequencer waits only if a
// second answer is ready before the first has gone.
// Reset empties the table (count zero) and drops any pending answer.
module arp_address_cache #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  arpc_in_if.sink      in_ch,
  arpc_out_if.source   out_ch
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [IDX_W-1:0]                  rd_addr;
  arpc_pkg::entry_t                  rd_data;
  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_addr;
  arpc_pkg::entry_t                  wr_data;
  logic                              res_valid;
  logic                              res_take;
  arpc_pkg::result_t                 res;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W+arpc_pkg::COUNT_W-1:0] count_wide;

  logic                              out_valid_r;
  arpc_pkg::result_t                 out_res_r;
  logic [arpc_pkg::COUNT_W-1:0]      out_count_r;

  arpc_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  arpc_seq #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .in_ip     (in_ch.ip_address),
    .in_mac    (in_ch.mac_address),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .count     (count)
  );

  // count shown modulo 32
  assign count_wide = {{arpc_pkg::COUNT_W{1'b0}}, count};

  // output register takes a word when empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // answer payload
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r   <= res;
      out_count_r <= count_wide[arpc_pkg::COUNT_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.found_mac   = out_res_r.found_mac;
  assign out_ch.entry_count = out_count_r;

endmodule
